// ===== rtl/b2da_pkg.sv =====
// Shared constants and control types for the binary to decimal ASCII converter.
package b2da_pkg;

   localparam int DEFAULT_INPUT_BITS = 32;
   localparam int DIGIT_BITS         = 4;
   localparam int CHAR_BITS          = 6;
   localparam int LOG10_2_NUM        = 30103;
   localparam int LOG10_2_DEN        = 100000;

   localparam logic [CHAR_BITS-1:0]  ASCII_ZERO   = 6'd48;
   localparam logic [CHAR_BITS-1:0]  ASCII_NINE   = 6'd57;
   localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DABBLE_ADD   = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_CONVERT = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic skip;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bits_last;
      logic top_zero;
      logic digit_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// Top level of the binary to decimal ASCII converter.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_value[INPUT_BITS-1:0]
//   rsp      out        rsp_valid/rsp_stall   rsp_digit_char[5:0], rsp_last_digit
//
// An item is loaded, then the double-dabble step takes one input bit per cycle,
// then the digit shifter moves one digit per cycle while the output is not
// stalled, leading zero digits included, over D digits, D = number of decimal
// digits of 2^INPUT_BITS - 1.
// Reset clears the state machine and the output valid; nothing else is kept.
// A stalled output holds the digit shifter; a new item is taken once the last
// digit of the previous one sits in the output register.
module binary_to_decimal_ascii_top #(
   parameter int INPUT_BITS = b2da_pkg::DEFAULT_INPUT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [INPUT_BITS-1:0]          req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [b2da_pkg::CHAR_BITS-1:0] rsp_digit_char,
   output logic                           rsp_last_digit
);
   import b2da_pkg::*;

   cmd_type    cmd;
   status_type status;

   b2da_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   b2da_datapath #(
      .INPUT_BITS (INPUT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

`ifndef SYNTHESIS
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= ASCII_ZERO && rsp_digit_char <= ASCII_NINE))
      else $error("digit character out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while busy");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.dabble, cmd.skip, cmd.emit}))
      else $error("conflicting datapath commands");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("digit emitted into a full output register");
`endif

endmodule

// ===== rtl/b2da_datapath.sv =====
// Datapath: value shifter, BCD register with add-3 correction, counters and output register.
module b2da_datapath #(
   parameter int INPUT_BITS = b2da_pkg::DEFAULT_INPUT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  b2da_pkg::cmd_type              cmd,
   output b2da_pkg::status_type           status,
   input  logic [INPUT_BITS-1:0]          req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [b2da_pkg::CHAR_BITS-1:0] rsp_digit_char,
   output logic                           rsp_last_digit
);
   import b2da_pkg::*;

   localparam int NUM_DIGITS = (INPUT_BITS * LOG10_2_NUM) / LOG10_2_DEN + 1;
   localparam int BCD_BITS   = NUM_DIGITS * DIGIT_BITS;
   localparam int BIT_CNT_W  = $clog2(INPUT_BITS);
   localparam int DIG_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   logic [INPUT_BITS-1:0]  value_ff, value_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in, bcd_adj;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]   char_ff, char_in;
   logic                   last_ff, last_in;
   logic [DIGIT_BITS-1:0]  top_digit;

   assign top_digit = bcd_ff[BCD_BITS-1 -: DIGIT_BITS];

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADD;
         end else begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   always_comb begin
      value_in   = value_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      if (cmd.load) begin
         value_in   = req_value;
         bcd_in     = '0;
         bit_cnt_in = BIT_CNT_W'(INPUT_BITS - 1);
         dig_cnt_in = DIG_CNT_W'(NUM_DIGITS - 1);
      end else if (cmd.dabble) begin
         value_in   = {value_ff[INPUT_BITS-2:0], 1'b0};
         bcd_in     = {bcd_adj[BCD_BITS-2:0], value_ff[INPUT_BITS-1]};
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end else if (cmd.skip || cmd.emit) begin
         bcd_in     = {bcd_ff[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
         dig_cnt_in = dig_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         char_in      = ASCII_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top_digit};
         last_in      = (dig_cnt_ff == '0);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.bits_last  = (bit_cnt_ff == '0);
   assign status.top_zero   = (top_digit == '0);
   assign status.digit_last = (dig_cnt_ff == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

// ===== rtl/b2da_controller.sv =====
// Controller: sequences load, bit-serial conversion and digit emission.
module b2da_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  b2da_pkg::status_type status,
   output b2da_pkg::cmd_type    cmd
);
   import b2da_pkg::*;

   state_type state_ff, state_in;
   logic      started_ff, started_in;

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load   = 1'b1;
               started_in = 1'b0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
            if (status.bits_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (status.top_zero && !status.digit_last && !started_ff) begin
                  cmd.skip = 1'b1;
               end else begin
                  cmd.emit   = 1'b1;
                  started_in = 1'b1;
                  if (status.digit_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the binary to decimal ASCII converter.
module tb;
   import b2da_pkg::*;

   localparam int VALUE_BITS   = 32;
   localparam int TEXT_BITS    = 80;
   localparam int DIR_COUNT    = 20;
   localparam int RANDOM_COUNT = 310;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 16;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last;
   } digit_item_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [TEXT_BITS-1:0]  text;
   } vector_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAR_BITS-1:0]  rsp_digit_char;
   logic                  rsp_last_digit;

   digit_item_type digits_due [$];
   logic           quiet = 1'b0;
   int unsigned    mismatch_count = 0;
   int unsigned    values_sent = 0;
   int unsigned    digits_checked = 0;
   logic [10:1]    lengths_seen = '0;

   // empty text: take the digits from the predictor
   vector_row_type directed_rows [DIR_COUNT] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'd99,         "99"},
      '{32'd100,        "100"},
      '{32'd4294967295, "4294967295"},
      '{32'd4294967294, "4294967294"},
      '{32'd2147483648, "2147483648"},
      '{32'd2147483647, "2147483647"},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999,  "999999999"},
      '{32'hAAAAAAAA,   80'h0},
      '{32'h55555555,   80'h0},
      '{32'd12345,      "12345"},
      '{32'h0F0F0F0F,   80'h0},
      '{32'd65535,      "65535"},
      '{32'd65536,      "65536"},
      '{32'hDEADBEEF,   80'h0},
      '{32'd0,          "0"}
   };

   binary_to_decimal_ascii_top #(
      .INPUT_BITS(VALUE_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   always #5 clock = ~clock;

   function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
      logic [DIGIT_BITS-1:0] rev [10];
      logic [VALUE_BITS-1:0] rest;
      int                    count;
      rest  = value;
      count = 0;
      do begin
         rev[count] = DIGIT_BITS'(rest % 10);
         rest       = rest / 10;
         count++;
      end while (rest != 0);
      for (int k = count - 1; k >= 0; k--) begin
         digits_due.push_back('{ASCII_ZERO + CHAR_BITS'(rev[k]), k == 0});
      end
   endfunction

   function automatic void load_typed_digits(input logic [TEXT_BITS-1:0] text);
      int count;
      count = 0;
      for (int i = 0; i < TEXT_BITS / 8; i++) begin
         if (text[i*8 +: 8] != 8'h00) count++;
      end
      for (int i = count - 1; i >= 0; i--) begin
         digits_due.push_back('{text[i*8 +: CHAR_BITS], i == 0});
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] raw;
      logic [VALUE_BITS-1:0] power;
      int unsigned           pick;
      raw  = $urandom();
      pick = $urandom_range(9);
      power = 1;
      case (pick)
         0, 1, 2, 3: random_value = raw;
         4, 5, 6:    random_value = raw >> $urandom_range(31);
         7: begin
            repeat ($urandom_range(9)) power = power * 10;
            random_value = power + $urandom_range(2) - 1;
         end
         8:          random_value = {VALUE_BITS{1'b1}} >> $urandom_range(31);
         default:    random_value = $urandom_range(20);
      endcase
   endfunction

   task automatic send_value(input logic [VALUE_BITS-1:0] value,
                             input logic [TEXT_BITS-1:0]  text);
      logic taken;
      int   size_before;
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      size_before = digits_due.size();
      if (text != '0) load_typed_digits(text);
      else predict_digits(value);
      lengths_seen[digits_due.size() - size_before] = 1'b1;
      values_sent++;
   endtask

   task automatic report_mismatch(input digit_item_type want, input digit_item_type got,
                                  input logic none_due);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         if (none_due)
            $display("mismatch: digit %0d last %0d with no digit due",
                     got.char_code, got.last);
         else
            $display("mismatch: expected digit %0d last %0d, got digit %0d last %0d",
                     want.char_code, want.last, got.char_code, got.last);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(negedge clock) begin : rsp_check
      digit_item_type got;
      digit_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_digit_char, rsp_last_digit};
         if (digits_due.size() == 0) begin
            report_mismatch(got, got, 1'b1);
         end else begin
            want = digits_due.pop_front();
            if (got.char_code !== want.char_code || got.last !== want.last)
               report_mismatch(want, got, 1'b0);
            digits_checked++;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout with %0d digits still due", digits_due.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < DIR_COUNT; r++) begin
         send_value(directed_rows[r].value, directed_rows[r].text);
      end
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         quiet <= (n >= 120 && n < 200);
         send_value(random_value(), '0);
      end
      req_valid <= 1'b0;
      quiet     <= 1'b0;
      while (digits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("converted %0d values, checked %0d digits, %0d mismatches",
               values_sent, digits_checked, mismatch_count);
      $display("digit counts seen (10 down to 1): %b", lengths_seen);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
